### hdl/sapt_pkg.sv
// Package with the sizes, codes and shared types of the sorted address predecessor table.
package sapt_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ID_WIDTH    = 16;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned IN_ID_W = 16;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned USED_W  = 11;
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W = ADDR_W + ID_WIDTH;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_LOOKUP = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FETCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   addr;
    logic [ID_WIDTH-1:0] id;
    logic [CNT_W-1:0]    count;
  } result_t;

  function automatic logic [ID_WIDTH-1:0] id_in(input logic [IN_ID_W-1:0] x);
    logic [31:0]         t;
    logic [ID_WIDTH-1:0] r;
    t = 32'(x);
    for (int i = 0; i < int'(ID_WIDTH); i++) begin
      r[i] = t[i];
    end
    return r;
  endfunction

  function automatic logic [IN_ID_W-1:0] id_out(input logic [ID_WIDTH-1:0] x);
    logic [31:0] t;
    t = '0;
    for (int i = 0; i < int'(ID_WIDTH); i++) begin
      t[i] = x[i];
    end
    return t[IN_ID_W-1:0];
  endfunction

endpackage

### hdl/sapt_if.sv
// Handshake interfaces for the request and result words of the table.
interface sapt_in_if;
  import sapt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ADDR_W-1:0]    key_address;
  logic [IN_ID_W-1:0]   entry_id;
  modport source (output valid, output func, output key_address, output entry_id,
                  input ready);
  modport sink (input valid, input func, input key_address, input entry_id,
                output ready);
endinterface

interface sapt_out_if;
  import sapt_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ADDR_W-1:0]  found_address;
  logic [IN_ID_W-1:0] found_id;
  logic [USED_W-1:0]  used_count;
  modport source (output valid, output status, output found_address, output found_id,
                  output used_count, input ready);
  modport sink (input valid, input status, input found_address, input found_id,
                input used_count, output ready);
endinterface

### hdl/sapt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module sapt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sapt_ctrl.sv
// Sequencer that searches, shifts and updates the sorted table held in the RAM.
module sapt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  sapt_in_if.sink            in_i,
  output sapt_pkg::mem_req_t mem_o,
  input  sapt_pkg::entry_t   rdata_i,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output sapt_pkg::result_t  res_o
);
  import sapt_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [CNT_W-1:0]    mid_q, mid_d;
  logic                pend_q, pend_d;
  logic                incl_q, incl_d;
  func_e               op_q, op_d;
  logic [ADDR_W-1:0]   key_q, key_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  result_t             res_q, res_d;

  logic                below;
  logic [CNT_W-1:0]    lo_c, hi_c, mid_c, prev_c, rd_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    incl_q <= incl_d;
    op_q   <= op_d;
    key_q  <= key_d;
    id_q   <= id_d;
    res_q  <= res_d;
  end

  // The search bounds fold in the entry read in the previous cycle.
  always_comb begin
    below = incl_q ? (rdata_i.addr <= key_q) : (rdata_i.addr < key_q);
    lo_c  = lo_q;
    hi_c  = hi_q;
    if (pend_q) begin
      if (below) begin
        lo_c = mid_q + 1'b1;
      end else begin
        hi_c = mid_q;
      end
    end
    mid_c  = lo_c + ((hi_c - lo_c) >> 1);
    prev_c = lo_c - 1'b1;
    rd_c   = hi_q - 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pend_d      = pend_q;
    incl_d      = incl_q;
    op_d        = op_q;
    key_d       = key_q;
    id_d        = id_q;
    res_d       = res_q;
    mem_o.re    = 1'b0;
    mem_o.raddr = '0;
    mem_o.we    = 1'b0;
    mem_o.waddr = '0;
    mem_o.wdata = rdata_i;
    in_i.ready  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          key_d        = in_i.key_address;
          id_d         = id_in(in_i.entry_id);
          op_d         = func_e'(in_i.func);
          lo_d         = '0;
          hi_d         = count_q;
          pend_d       = 1'b0;
          res_d.status = STAT_OK;
          res_d.addr   = '0;
          res_d.id     = '0;
          res_d.count  = count_q;
          case (in_i.func)
            FN_CLEAR: begin
              count_d     = '0;
              res_d.count = '0;
              state_d     = S_DONE;
            end
            FN_INSERT: begin
              if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                res_d.status = STAT_FULL;
                state_d      = S_DONE;
              end else begin
                incl_d  = 1'b1;
                state_d = S_SEARCH;
              end
            end
            FN_LOOKUP: begin
              incl_d  = 1'b0;
              state_d = S_SEARCH;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        lo_d = lo_c;
        hi_d = hi_c;
        if (lo_c < hi_c) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = mid_c[IDX_W-1:0];
          mid_d       = mid_c;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (op_q == FN_INSERT) begin
            // Move entries from the top down to the insertion point.
            hi_d    = count_q;
            state_d = S_SHIFT;
          end else if (lo_c == '0 || lo_c >= count_q) begin
            res_d.status = STAT_MISS;
            state_d      = S_DONE;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = prev_c[IDX_W-1:0];
            state_d     = S_FETCH;
          end
        end
      end

      S_SHIFT: begin
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = mid_q[IDX_W-1:0];
          mem_o.wdata = rdata_i;
        end
        if (hi_q > lo_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = rd_c[IDX_W-1:0];
          mid_d       = hi_q;
          hi_d        = rd_c;
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_o.we         = 1'b1;
            mem_o.waddr      = lo_q[IDX_W-1:0];
            mem_o.wdata.addr = key_q;
            mem_o.wdata.id   = id_q;
            count_d          = count_q + 1'b1;
            res_d.count      = count_q + 1'b1;
            state_d          = S_DONE;
          end
        end
      end

      S_FETCH: begin
        res_d.status = STAT_OK;
        res_d.addr   = rdata_i.addr;
        res_d.id     = rdata_i.id;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

### hdl/sorted_address_predecessor_table.sv
// Top level of the sorted address predecessor table: sequencer, entry RAM and result register.
// Clear and an insert into a full table go from acceptance straight to the done state, with no RAM access.
// Lookup binary-searches the entries, one search step per RAM read, then reads the predecessor.
// Insert searches alike, then shifts entries from the insertion point up, one entry moved per cycle.
// One word is in work at a time; the next is taken while a result waits in the output register.
// Reset empties the table at once; the RAM contents are left undefined and never cleared.
module sorted_address_predecessor_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  sapt_in_if.sink    in_i,
  sapt_out_if.source out_o
);
  import sapt_pkg::*;

  mem_req_t mem_req;
  entry_t   rdata;
  result_t  res;
  logic     res_valid;
  logic     out_free;
  logic     out_valid_q;
  result_t  out_q;

  assign out_free = !out_valid_q || out_o.ready;

  sapt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mem_o       (mem_req),
    .rdata_i     (rdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sapt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.found_address = out_q.addr;
  assign out_o.found_id      = id_out(out_q.id);
  assign out_o.used_count    = USED_W'(out_q.count);

endmodule
